FILE: rtl/core/mdpc_pkg.sv
// Shared constants for the moving disc pair clearance unit.
// Coordinate width and all derived datapath widths; no dependencies.
package mdpc_pkg;

  // Coordinate and radius widths
  localparam int COORD_BITS  = 16;
  localparam int RADIUS_BITS = 15;

  // Relative offset (b_start - a_start) and relative motion widths, signed
  localparam int D_W = COORD_BITS + 1;
  localparam int L_W = COORD_BITS + 2;

  // Squares and dot products of the relative terms
  localparam int SQL_W = 2 * COORD_BITS + 2;
  localparam int SQD_W = 2 * COORD_BITS;
  localparam int DOT_W = 2 * COORD_BITS + 2;

  // Quadratic coefficients: alpha, beta (signed), gamma
  localparam int QW    = 2 * COORD_BITS + 3;
  localparam int GAM_W = 2 * COORD_BITS + 1;

  // Squared diameter 4r^2 and the gamma - 4r^2 difference with borrow bit
  localparam int R2_W   = 2 * RADIUS_BITS + 2;
  localparam int DIFF_W = ((QW > R2_W) ? QW : R2_W) + 1;

  // Split multiplier: QW-bit operands cut into two halves
  localparam int HW     = (QW + 1) / 2;
  localparam int PP_W   = 2 * HW;
  localparam int PROD_W = 4 * HW;

  // Register stages from input to result
  localparam int STAGES = 7;

endpackage

FILE: rtl/core/mdpc_in_if.sv
// Input channel of the clearance unit: one word is the two robot paths.
// Depends on mdpc_pkg for the coordinate width.
interface mdpc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mdpc_pkg::COORD_BITS-1:0] robot_a_start_x;
  logic signed [mdpc_pkg::COORD_BITS-1:0] robot_a_start_y;
  logic signed [mdpc_pkg::COORD_BITS-1:0] robot_a_end_x;
  logic signed [mdpc_pkg::COORD_BITS-1:0] robot_a_end_y;
  logic signed [mdpc_pkg::COORD_BITS-1:0] robot_b_start_x;
  logic signed [mdpc_pkg::COORD_BITS-1:0] robot_b_start_y;
  logic signed [mdpc_pkg::COORD_BITS-1:0] robot_b_end_x;
  logic signed [mdpc_pkg::COORD_BITS-1:0] robot_b_end_y;

  modport source (
    output valid, robot_a_start_x, robot_a_start_y, robot_a_end_x, robot_a_end_y,
    output robot_b_start_x, robot_b_start_y, robot_b_end_x, robot_b_end_y,
    input  ready
  );

  modport sink (
    input  valid, robot_a_start_x, robot_a_start_y, robot_a_end_x, robot_a_end_y,
    input  robot_b_start_x, robot_b_start_y, robot_b_end_x, robot_b_end_y,
    output ready
  );
endinterface

FILE: rtl/core/mdpc_out_if.sv
// Result channel of the clearance unit: one word is the two result flags.
// No dependencies.
interface mdpc_out_if;
  logic valid;
  logic ready;
  logic pair_clear;
  logic interior_minimum;

  modport source (
    output valid, pair_clear, interior_minimum,
    input  ready
  );

  modport sink (
    input  valid, pair_clear, interior_minimum,
    output ready
  );
endinterface

FILE: rtl/core/moving_disc_pair_clearance_unit.sv
// Clearance check for two disc robots moving linearly over one time unit. A word
// enters on every clock unless the result side stalls; throughput is one word per
// cycle, set by the seven-stage pipeline whose stages hold adder levels, full-width
// multipliers, half-width multipliers or compares. The test 4r^2*alpha + beta^2 <
// gamma*alpha is evaluated as alpha*(gamma - 4r^2) > beta^2 with two 2x2-split
// products. A radius write takes effect on the next cycle; write it only while no
// word is in flight. A stall on the result side holds every stage that is full and
// lets bubbles close up, so nothing is lost or repeated.
// Depends on mdpc_pkg, mdpc_in_if and mdpc_out_if.
module moving_disc_pair_clearance_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mdpc_pkg::RADIUS_BITS-1:0] cfg_wr_data,
  mdpc_in_if.sink                        in_chan,
  mdpc_out_if.source                     out_chan
);

  localparam int NST = mdpc_pkg::STAGES;
  localparam int HW  = mdpc_pkg::HW;

  // Squared diameter, kept as 4r^2
  logic [mdpc_pkg::R2_W-1:0]          four_r2_r;
  logic [2*mdpc_pkg::RADIUS_BITS-1:0] r_sq;

  assign r_sq = (2*mdpc_pkg::RADIUS_BITS)'(cfg_wr_data)
              * (2*mdpc_pkg::RADIUS_BITS)'(cfg_wr_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_r2_r <= '0;
    end else if (cfg_wr_en) begin
      four_r2_r <= {r_sq, 2'b00};
    end
  end

  // Valid bits and stage advance chain
  logic [NST-1:0] v_r;
  logic [NST:0]   adv;

  always_comb begin
    adv[NST] = out_chan.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_chan.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: relative offset and relative motion
  logic signed [mdpc_pkg::D_W-1:0] dx_r, dy_r;
  logic signed [mdpc_pkg::L_W-1:0] lx_r, ly_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx_r <= mdpc_pkg::D_W'(in_chan.robot_b_start_x) - mdpc_pkg::D_W'(in_chan.robot_a_start_x);
      dy_r <= mdpc_pkg::D_W'(in_chan.robot_b_start_y) - mdpc_pkg::D_W'(in_chan.robot_a_start_y);
      lx_r <= mdpc_pkg::L_W'(in_chan.robot_b_end_x) - mdpc_pkg::L_W'(in_chan.robot_b_start_x)
            - mdpc_pkg::L_W'(in_chan.robot_a_end_x) + mdpc_pkg::L_W'(in_chan.robot_a_start_x);
      ly_r <= mdpc_pkg::L_W'(in_chan.robot_b_end_y) - mdpc_pkg::L_W'(in_chan.robot_b_start_y)
            - mdpc_pkg::L_W'(in_chan.robot_a_end_y) + mdpc_pkg::L_W'(in_chan.robot_a_start_y);
    end
  end

  // Stage 2: squares and dot-product terms
  logic signed [2*mdpc_pkg::L_W-1:0]           sq_lx_full, sq_ly_full;
  logic signed [2*mdpc_pkg::D_W-1:0]           sq_dx_full, sq_dy_full;
  logic signed [mdpc_pkg::D_W+mdpc_pkg::L_W-1:0] dl_x_full, dl_y_full;
  logic [mdpc_pkg::SQL_W-1:0]                  sq_lx_r, sq_ly_r;
  logic [mdpc_pkg::SQD_W-1:0]                  sq_dx_r, sq_dy_r;
  logic signed [mdpc_pkg::DOT_W-1:0]           dl_x_r, dl_y_r;

  assign sq_lx_full = (2*mdpc_pkg::L_W)'(lx_r) * (2*mdpc_pkg::L_W)'(lx_r);
  assign sq_ly_full = (2*mdpc_pkg::L_W)'(ly_r) * (2*mdpc_pkg::L_W)'(ly_r);
  assign sq_dx_full = (2*mdpc_pkg::D_W)'(dx_r) * (2*mdpc_pkg::D_W)'(dx_r);
  assign sq_dy_full = (2*mdpc_pkg::D_W)'(dy_r) * (2*mdpc_pkg::D_W)'(dy_r);
  assign dl_x_full  = (mdpc_pkg::D_W+mdpc_pkg::L_W)'(dx_r)
                    * (mdpc_pkg::D_W+mdpc_pkg::L_W)'(lx_r);
  assign dl_y_full  = (mdpc_pkg::D_W+mdpc_pkg::L_W)'(dy_r)
                    * (mdpc_pkg::D_W+mdpc_pkg::L_W)'(ly_r);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sq_lx_r <= sq_lx_full[mdpc_pkg::SQL_W-1:0];
      sq_ly_r <= sq_ly_full[mdpc_pkg::SQL_W-1:0];
      sq_dx_r <= sq_dx_full[mdpc_pkg::SQD_W-1:0];
      sq_dy_r <= sq_dy_full[mdpc_pkg::SQD_W-1:0];
      dl_x_r  <= dl_x_full[mdpc_pkg::DOT_W-1:0];
      dl_y_r  <= dl_y_full[mdpc_pkg::DOT_W-1:0];
    end
  end

  // Stage 3: quadratic coefficients alpha, beta, gamma
  logic [mdpc_pkg::QW-1:0]        alpha3_r;
  logic signed [mdpc_pkg::QW-1:0] beta3_r;
  logic [mdpc_pkg::GAM_W-1:0]     gamma3_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      alpha3_r <= mdpc_pkg::QW'(sq_lx_r) + mdpc_pkg::QW'(sq_ly_r);
      beta3_r  <= mdpc_pkg::QW'(dl_x_r) + mdpc_pkg::QW'(dl_y_r);
      gamma3_r <= mdpc_pkg::GAM_W'(sq_dx_r) + mdpc_pkg::GAM_W'(sq_dy_r);
    end
  end

  // Stage 4: beta magnitude and clipped gamma - 4r^2
  logic [mdpc_pkg::DIFF_W-1:0] diff;
  logic [mdpc_pkg::QW-1:0]     alpha4_r, bmag4_r, e4_r;
  logic                        bneg4_r;

  assign diff = mdpc_pkg::DIFF_W'(gamma3_r) - mdpc_pkg::DIFF_W'(four_r2_r);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      alpha4_r <= alpha3_r;
      bneg4_r  <= beta3_r[mdpc_pkg::QW-1];
      bmag4_r  <= -beta3_r;
      // negative difference can never pass, so drop it to zero
      e4_r     <= diff[mdpc_pkg::DIFF_W-1] ? '0 : diff[mdpc_pkg::QW-1:0];
    end
  end

  // Stage 5: interior test and half-width partial products
  logic [2*HW-1:0]           a_pad, e_pad, b_pad;
  logic [mdpc_pkg::PP_W-1:0] ae_ll, ae_lh, ae_hl, ae_hh;
  logic [mdpc_pkg::PP_W-1:0] bb_ll, bb_lh, bb_hh;
  logic [mdpc_pkg::PP_W-1:0] ae_ll_r, ae_lh_r, ae_hl_r, ae_hh_r;
  logic [mdpc_pkg::PP_W-1:0] bb_ll_r, bb_lh_r, bb_hh_r;
  logic                      int5_r;

  assign a_pad = (2*HW)'(alpha4_r);
  assign e_pad = (2*HW)'(e4_r);
  assign b_pad = (2*HW)'(bmag4_r);

  assign ae_ll = mdpc_pkg::PP_W'(a_pad[HW-1:0])    * mdpc_pkg::PP_W'(e_pad[HW-1:0]);
  assign ae_lh = mdpc_pkg::PP_W'(a_pad[HW-1:0])    * mdpc_pkg::PP_W'(e_pad[2*HW-1:HW]);
  assign ae_hl = mdpc_pkg::PP_W'(a_pad[2*HW-1:HW]) * mdpc_pkg::PP_W'(e_pad[HW-1:0]);
  assign ae_hh = mdpc_pkg::PP_W'(a_pad[2*HW-1:HW]) * mdpc_pkg::PP_W'(e_pad[2*HW-1:HW]);
  assign bb_ll = mdpc_pkg::PP_W'(b_pad[HW-1:0])    * mdpc_pkg::PP_W'(b_pad[HW-1:0]);
  assign bb_lh = mdpc_pkg::PP_W'(b_pad[HW-1:0])    * mdpc_pkg::PP_W'(b_pad[2*HW-1:HW]);
  assign bb_hh = mdpc_pkg::PP_W'(b_pad[2*HW-1:HW]) * mdpc_pkg::PP_W'(b_pad[2*HW-1:HW]);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      int5_r  <= (alpha4_r != '0) && bneg4_r && (bmag4_r < alpha4_r);
      ae_ll_r <= ae_ll;
      ae_lh_r <= ae_lh;
      ae_hl_r <= ae_hl;
      ae_hh_r <= ae_hh;
      bb_ll_r <= bb_ll;
      bb_lh_r <= bb_lh;
      bb_hh_r <= bb_hh;
    end
  end

  // Stage 6: recombine the partial products
  logic [mdpc_pkg::PROD_W-1:0] p_ae_r, p_bb_r;
  logic                        int6_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      int6_r <= int5_r;
      p_ae_r <= (mdpc_pkg::PROD_W'(ae_hh_r) << (2*HW)) + mdpc_pkg::PROD_W'(ae_ll_r)
              + ((mdpc_pkg::PROD_W'(ae_lh_r) + mdpc_pkg::PROD_W'(ae_hl_r)) << HW);
      p_bb_r <= (mdpc_pkg::PROD_W'(bb_hh_r) << (2*HW)) + mdpc_pkg::PROD_W'(bb_ll_r)
              + (mdpc_pkg::PROD_W'(bb_lh_r) << (HW + 1));
    end
  end

  // Stage 7: final compare into the output register
  logic clear_r, int7_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      int7_r  <= int6_r;
      clear_r <= !int6_r || (p_ae_r > p_bb_r);
    end
  end

  assign out_chan.valid            = v_r[NST-1];
  assign out_chan.pair_clear       = clear_r;
  assign out_chan.interior_minimum = int7_r;

`ifndef SYNTH
  // a pair can only fail when the closest approach is interior
  a_fail_needs_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.pair_clear |-> out_chan.interior_minimum)
    else $error("pair reported not clear without interior minimum");

  // an accepted word lands in the first stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> v_r[0])
    else $error("accepted word missing from first stage");

  // a full stage with a blocked successor keeps its word
  a_stall_holds_s3: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] && !adv[3] |=> v_r[2])
    else $error("stalled word dropped from third stage");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for moving_disc_pair_clearance_unit: a directed table, then random
// path pairs under several radius settings, each result word checked against a typed or predicted expectation.
// Depends on mdpc_pkg, mdpc_in_if, mdpc_out_if and the unit itself.
module tb_top;

  typedef logic signed [mdpc_pkg::COORD_BITS-1:0] coord_t;
  typedef logic [mdpc_pkg::RADIUS_BITS-1:0] radius_t;

  typedef struct packed {
    coord_t robot_a_start_x;
    coord_t robot_a_start_y;
    coord_t robot_a_end_x;
    coord_t robot_a_end_y;
    coord_t robot_b_start_x;
    coord_t robot_b_start_y;
    coord_t robot_b_end_x;
    coord_t robot_b_end_y;
  } path_pair_t;

  typedef struct packed {
    logic pair_clear;
    logic interior_minimum;
  } clearance_t;

  typedef enum bit {ROW_PREDICTED, ROW_TYPED} row_kind_t;
  typedef enum int {SHAPE_ANY, SHAPE_LOCAL, SHAPE_PARALLEL, SHAPE_GRAZE} shape_t;

  typedef struct {
    radius_t    radius;
    path_pair_t pair;
    row_kind_t  kind;
    clearance_t want;
  } plan_row_t;

  localparam int HALF_PERIOD = 4;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS = 100;
  localparam int LONG_HOLD = 48;
  localparam int HOLD_AFTER = 300;

  logic    clk;
  logic    rst_n;
  logic    cfg_wr_en;
  radius_t cfg_wr_data;

  mdpc_in_if  pair_in ();
  mdpc_out_if flags_out ();

  moving_disc_pair_clearance_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_chan    (pair_in),
    .out_chan   (flags_out)
  );

  clearance_t clearance_due[$];
  plan_row_t  plan[$];
  radius_t    radius_now;
  bit         stalls_on;
  bit         long_hold_done;
  int         mismatch_count;
  int         words_checked;
  int         interior_seen;
  int         clear_seen;
  int         radius_writes;
  clearance_t got_flags;
  clearance_t want_flags;

  // Clock
  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #2_000_000;
    $error("timeout: %0d results still outstanding", clearance_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Predict both flags from the closest-approach quadratic, exactly
  function automatic clearance_t clearance_of(input path_pair_t p, input radius_t r);
    longint dx, dy, lx, ly, alpha, gamma, beta, beta_mag;
    logic [127:0] four_r2, lhs, rhs;
    clearance_t c;
    dx = longint'($signed(p.robot_b_start_x)) - longint'($signed(p.robot_a_start_x));
    dy = longint'($signed(p.robot_b_start_y)) - longint'($signed(p.robot_a_start_y));
    lx = (longint'($signed(p.robot_b_end_x)) - longint'($signed(p.robot_b_start_x)))
       - (longint'($signed(p.robot_a_end_x)) - longint'($signed(p.robot_a_start_x)));
    ly = (longint'($signed(p.robot_b_end_y)) - longint'($signed(p.robot_b_start_y)))
       - (longint'($signed(p.robot_a_end_y)) - longint'($signed(p.robot_a_start_y)));
    alpha = lx * lx + ly * ly;
    gamma = dx * dx + dy * dy;
    beta = dx * lx + dy * ly;
    beta_mag = (beta < 0) ? -beta : beta;
    c.pair_clear = 1'b1;
    c.interior_minimum = 1'b0;
    // Minimum strictly inside the move: compare 4r^2*alpha + beta^2 with gamma*alpha
    if (alpha != 0 && beta < 0 && beta_mag < alpha) begin
      four_r2 = 128'(r) * 128'(r) * 128'd4;
      lhs = four_r2 * 128'(alpha) + 128'(beta_mag) * 128'(beta_mag);
      rhs = 128'(gamma) * 128'(alpha);
      c.interior_minimum = 1'b1;
      c.pair_clear = (lhs < rhs);
    end
    return c;
  endfunction

  function automatic path_pair_t pack_pair(input int asx, asy, aex, aey, bsx, bsy, bex, bey);
    path_pair_t p;
    p.robot_a_start_x = coord_t'(asx);
    p.robot_a_start_y = coord_t'(asy);
    p.robot_a_end_x   = coord_t'(aex);
    p.robot_a_end_y   = coord_t'(aey);
    p.robot_b_start_x = coord_t'(bsx);
    p.robot_b_start_y = coord_t'(bsy);
    p.robot_b_end_x   = coord_t'(bex);
    p.robot_b_end_y   = coord_t'(bey);
    return p;
  endfunction

  function automatic void add_row(input int r, asx, asy, aex, aey, bsx, bsy, bex, bey,
                                  input row_kind_t kind, input bit clr, input bit intr);
    plan_row_t row;
    row.radius = radius_t'(r);
    row.pair = pack_pair(asx, asy, aex, aey, bsx, bsy, bex, bey);
    row.kind = kind;
    row.want.pair_clear = clr;
    row.want.interior_minimum = intr;
    plan.push_back(row);
  endfunction

  // Random path pair; most shapes keep the minimum near the diameter or inside the move
  function automatic path_pair_t random_pair(input radius_t r);
    int pick, cx, cy, k, h, mx, my, ax, ay, bx, by;
    shape_t shape;
    pick = $urandom_range(0, 99);
    shape = (pick < 35) ? SHAPE_ANY : (pick < 60) ? SHAPE_LOCAL :
            (pick < 75) ? SHAPE_PARALLEL : SHAPE_GRAZE;
    case (shape)
      SHAPE_LOCAL: begin
        cx = int'($urandom_range(0, 60000)) - 30000;
        cy = int'($urandom_range(0, 60000)) - 30000;
        return pack_pair(cx + int'($urandom_range(0, 600)) - 300,
                         cy + int'($urandom_range(0, 600)) - 300,
                         cx + int'($urandom_range(0, 600)) - 300,
                         cy + int'($urandom_range(0, 600)) - 300,
                         cx + int'($urandom_range(0, 600)) - 300,
                         cy + int'($urandom_range(0, 600)) - 300,
                         cx + int'($urandom_range(0, 600)) - 300,
                         cy + int'($urandom_range(0, 600)) - 300);
      end
      SHAPE_PARALLEL: begin
        mx = int'($urandom_range(0, 32000)) - 16000;
        my = int'($urandom_range(0, 32000)) - 16000;
        ax = int'($urandom_range(0, 32000)) - 16000;
        ay = int'($urandom_range(0, 32000)) - 16000;
        bx = int'($urandom_range(0, 32000)) - 16000;
        by = int'($urandom_range(0, 32000)) - 16000;
        return pack_pair(ax, ay, ax + mx, ay + my, bx, by, bx + mx, by + my);
      end
      SHAPE_GRAZE: begin
        // Head-on pass with lateral gap at the diameter, one below or one above
        h = 2 * int'(r) + int'($urandom_range(0, 2)) - 1;
        if (h < 0) h = 0;
        if (h > 65535) h = 65535;
        cy = -32768 + int'($urandom_range(0, 65535 - h));
        cx = int'($urandom_range(0, 32000)) - 16000;
        k = $urandom_range(1, 16000);
        if ($urandom_range(0, 1))
          return pack_pair(cy, cx - k, cy, cx + k, cy + h, cx + k, cy + h, cx - k);
        return pack_pair(cx - k, cy, cx + k, cy, cx + k, cy + h, cx - k, cy + h);
      end
      default: begin
        return pack_pair($urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), $urandom());
      end
    endcase
  endfunction

  // Offer one word from a falling edge, record its expectation at acceptance
  task automatic send_pair(input path_pair_t p, input clearance_t want);
    if (stalls_on && $urandom_range(0, 7) == 0) begin
      pair_in.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pair_in.valid           <= 1'b1;
    pair_in.robot_a_start_x <= p.robot_a_start_x;
    pair_in.robot_a_start_y <= p.robot_a_start_y;
    pair_in.robot_a_end_x   <= p.robot_a_end_x;
    pair_in.robot_a_end_y   <= p.robot_a_end_y;
    pair_in.robot_b_start_x <= p.robot_b_start_x;
    pair_in.robot_b_start_y <= p.robot_b_start_y;
    pair_in.robot_b_end_x   <= p.robot_b_end_x;
    pair_in.robot_b_end_y   <= p.robot_b_end_y;
    @(posedge clk);
    while (!pair_in.ready) @(posedge clk);
    clearance_due.push_back(want);
    @(negedge clk);
  endtask

  // Drop valid and hold until every word in flight has come out
  task automatic finish_in_flight();
    pair_in.valid <= 1'b0;
    while (clearance_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_radius(input radius_t r);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    radius_now = r;
    radius_writes++;
  endtask

  // Result side: random short stalls, one long hold-off to back the pipeline up
  initial begin
    flags_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        flags_out.ready <= 1'b0;
      end else if (!long_hold_done && words_checked >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        flags_out.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        flags_out.ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        flags_out.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && flags_out.valid && flags_out.ready) begin
      got_flags.pair_clear = flags_out.pair_clear;
      got_flags.interior_minimum = flags_out.interior_minimum;
      if (clearance_due.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatch_count++;
      end else begin
        want_flags = clearance_due.pop_front();
        if (got_flags.pair_clear !== want_flags.pair_clear) begin
          $error("pair_clear: expected %0b, actual %0b",
                 want_flags.pair_clear, got_flags.pair_clear);
          mismatch_count++;
        end
        if (got_flags.interior_minimum !== want_flags.interior_minimum) begin
          $error("interior_minimum: expected %0b, actual %0b",
                 want_flags.interior_minimum, got_flags.interior_minimum);
          mismatch_count++;
        end
        words_checked++;
        if (want_flags.interior_minimum) interior_seen++;
        if (want_flags.pair_clear) clear_seen++;
      end
    end
  end

  // Stimulus
  initial begin
    radius_t    next_radius;
    path_pair_t p;
    clearance_t want;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    pair_in.valid = 1'b0;
    pair_in.robot_a_start_x = '0;
    pair_in.robot_a_start_y = '0;
    pair_in.robot_a_end_x = '0;
    pair_in.robot_a_end_y = '0;
    pair_in.robot_b_start_x = '0;
    pair_in.robot_b_start_y = '0;
    pair_in.robot_b_end_x = '0;
    pair_in.robot_b_end_y = '0;
    radius_now = '0;
    stalls_on = 1'b1;
    long_hold_done = 1'b0;
    mismatch_count = 0;
    words_checked = 0;
    interior_seen = 0;
    clear_seen = 0;
    radius_writes = 0;

    //       radius  a start         a end           b start         b end
    // no motion at all
    add_row(    0,      0,      0,      0,      0,      0,      0,      0,      0,
            ROW_TYPED, 1, 0);
    // same motion for both, overlapping discs still count as clear
    add_row(  100,      0,      0,    100,      0,      0,     10,    100,     10,
            ROW_TYPED, 1, 0);
    // head-on through each other, zero radius touches
    add_row(    0,  -1000,      0,   1000,      0,   1000,      0,  -1000,      0,
            ROW_TYPED, 0, 1);
    // minimum distance exactly one diameter: not clear
    add_row(   25,  -1000,      0,   1000,      0,   1000,     50,  -1000,     50,
            ROW_TYPED, 0, 1);
    add_row(   24,  -1000,      0,   1000,      0,   1000,     50,  -1000,     50,
            ROW_TYPED, 1, 1);
    // closest approach at the start, at the end and past the end
    add_row(32767,      0,      0,      0,      0,    100,      0,    100,    100,
            ROW_TYPED, 1, 0);
    add_row(32767,      0,      0,      0,      0,    100,      0,      0,      0,
            ROW_TYPED, 1, 0);
    add_row(32767,      0,      0,      0,      0,    300,      0,    200,      0,
            ROW_TYPED, 1, 0);
    // full-range diagonal crossing and full-range pass one span apart
    add_row(32767, -32768, -32768,  32767,  32767,  32767,  32767, -32768, -32768,
            ROW_TYPED, 0, 1);
    add_row(32767, -32768, -32768,  32767, -32768,  32767,  32767, -32768,  32767,
            ROW_TYPED, 1, 1);
    add_row(32767,  32767,      0, -32768,      0, -32768,      1,  32767,      1,
            ROW_TYPED, 0, 1);
    add_row(32767,  12345, -23456, -32768,  32767, -32768,  32767,  32767, -32768,
            ROW_PREDICTED, 0, 0);
    add_row(    0,  32767,      0, -32768,      0, -32768,      1,  32767,      1,
            ROW_TYPED, 1, 1);
    add_row(    0, -32768, -32768,  32767,  32767,  32767,  32767, -32768, -32768,
            ROW_TYPED, 0, 1);
    add_row(    0,  32767,  32767,  32767,  32767,  32767,  32767,  32767,  32767,
            ROW_TYPED, 1, 0);
    add_row(    0, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
            ROW_TYPED, 1, 0);
    add_row(  200,    100,    -50,   -300,    400,    -20,     30,    250,   -410,
            ROW_PREDICTED, 0, 0);
    add_row( 1000, -32768,  32767,  32767, -32768,  12345, -23456, -32768,  32767,
            ROW_PREDICTED, 0, 0);
    add_row(    7,      5,      5,      6,      6,     20,      3,     -4,      9,
            ROW_PREDICTED, 0, 0);
    add_row(   12,      1,     -1,     -1,      1,     -2,      2,      3,     -3,
            ROW_PREDICTED, 0, 0);

    // Reset
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    foreach (plan[i]) begin
      if (plan[i].radius != radius_now) begin
        finish_in_flight();
        write_radius(plan[i].radius);
      end
      if (plan[i].kind == ROW_TYPED) want = plan[i].want;
      else want = clearance_of(plan[i].pair, radius_now);
      send_pair(plan[i].pair, want);
    end

    // Random phases, each under its own radius; the last one runs without stalls
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      finish_in_flight();
      case (phase)
        0:       next_radius = radius_t'($urandom_range(0, 64));
        1:       next_radius = '0;
        2:       next_radius = '1;
        4:       next_radius = radius_t'($urandom_range(0, 1024));
        5:       next_radius = radius_t'($urandom_range(1000, 32767));
        7:       next_radius = radius_t'($urandom_range(0, 300));
        default: next_radius = radius_t'($urandom_range(0, 32767));
      endcase
      write_radius(next_radius);
      if (phase == RANDOM_PHASES - 1) stalls_on = 1'b0;
      repeat (PHASE_WORDS) begin
        p = random_pair(radius_now);
        send_pair(p, clearance_of(p, radius_now));
      end
    end

    // Drain and let the pipeline settle
    finish_in_flight();
    repeat (mdpc_pkg::STAGES + 4) @(posedge clk);

    $display("Checked %0d clearance words over %0d radius settings:", words_checked,
             radius_writes + 1);
    $display("  %0d with interior minimum, %0d clear, long result hold-off %0s",
             interior_seen, clear_seen, long_hold_done ? "done" : "missed");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
